### design/tpr_pkg.sv
package tpr_pkg;
  localparam int TimeW  = 32;
  localparam int RpmW   = 24;
  localparam int RatioW = 16;
  localparam int CntW   = 32;
  localparam int CfgIdxW = 4;
  localparam int CfgDataW = 32;
  localparam int ProdW  = RpmW + RatioW;

  localparam logic [7:0] CONFIRM_PULSES = 8'd2;
  localparam logic [RatioW-1:0] CONFIRM_TOLERANCE_Q16 = 16'd6554;

  localparam logic [CfgIdxW-1:0] CFG_MIN_PULSE   = 4'd0;
  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT     = 4'd1;
  localparam logic [CfgIdxW-1:0] CFG_NUMERATOR   = 4'd2;
  localparam logic [CfgIdxW-1:0] CFG_MAX_RPM     = 4'd3;
  localparam logic [CfgIdxW-1:0] CFG_MIN_ENGINE  = 4'd4;
  localparam logic [CfgIdxW-1:0] CFG_LOW_RATIO   = 4'd5;
  localparam logic [CfgIdxW-1:0] CFG_HIGH_RATIO  = 4'd6;
  localparam logic [CfgIdxW-1:0] CFG_ALPHA       = 4'd7;

  localparam logic CMD_EDGE = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  typedef struct packed {
    logic start;
    logic done;
  } div_ctl_t;
endpackage

### design/tpr_if.sv
interface tpr_in_if;
  logic                      valid;
  logic                      ready;
  logic                      command;
  logic [tpr_pkg::TimeW-1:0] time_us;
  modport source (output valid, command, time_us, input ready);
  modport sink (input valid, command, time_us, output ready);
endinterface

interface tpr_out_if;
  logic                     valid;
  logic                     ready;
  logic [tpr_pkg::RpmW-1:0] filtered_rpm;
  logic [tpr_pkg::RpmW-1:0] raw_rpm;
  logic                     signal_present;
  logic [tpr_pkg::TimeW-1:0] period_us;
  logic [tpr_pkg::CntW-1:0] pulse_count;
  logic [tpr_pkg::CntW-1:0] rejected_pulse_count;
  logic [tpr_pkg::CntW-1:0] rejected_reading_count;
  logic [tpr_pkg::CntW-1:0] low_spike_count;
  logic [tpr_pkg::CntW-1:0] high_spike_count;
  logic [tpr_pkg::CntW-1:0] zero_drop_count;
  logic [tpr_pkg::RpmW-1:0] min_accepted_rpm;
  logic [tpr_pkg::RpmW-1:0] max_accepted_rpm;
  modport source (output valid, filtered_rpm, raw_rpm, signal_present, period_us,
    pulse_count, rejected_pulse_count, rejected_reading_count, low_spike_count,
    high_spike_count, zero_drop_count, min_accepted_rpm, max_accepted_rpm, input ready);
  modport sink (input valid, filtered_rpm, raw_rpm, signal_present, period_us,
    pulse_count, rejected_pulse_count, rejected_reading_count, low_spike_count,
    high_spike_count, zero_drop_count, min_accepted_rpm, max_accepted_rpm, output ready);
endinterface

interface tpr_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [tpr_pkg::CfgIdxW-1:0]  index;
  logic [tpr_pkg::CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### design/tpr_div.sv
module tpr_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  tpr_pkg::div_ctl_t         ctl_in,
  input  logic [tpr_pkg::TimeW-1:0] num,
  input  logic [tpr_pkg::TimeW-1:0] den,
  output logic                      done,
  output logic [tpr_pkg::TimeW-1:0] quo
);
  import tpr_pkg::*;

  localparam int StepW = $clog2(TimeW);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [StepW-1:0] step_r, step_nxt;
  logic [TimeW:0]   rem_r, rem_nxt;
  logic [TimeW-1:0] quo_r, quo_nxt;
  logic [TimeW-1:0] den_r, den_nxt;
  logic [TimeW:0]   shifted;
  logic [TimeW:0]   diff;

  // restoring division, one quotient bit per cycle; quotient shifts in from the numerator
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    shifted  = {rem_r[TimeW-1:0], quo_r[TimeW-1]};
    diff     = shifted - {1'b0, den_r};
    if (ctl_in.start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = '0;
      quo_nxt  = num;
      den_nxt  = den;
    end else if (busy_r) begin
      if (!diff[TimeW]) begin
        rem_nxt = diff;
        quo_nxt = {quo_r[TimeW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        quo_nxt = {quo_r[TimeW-2:0], 1'b0};
      end
      step_nxt = step_r + 1'b1;
      if (step_r == StepW'(TimeW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;
endmodule

### design/tpr_mul.sv
module tpr_mul (
  input  logic                       clk,
  input  logic [tpr_pkg::RpmW-1:0]   a,
  input  logic [tpr_pkg::RatioW-1:0] b,
  output logic [tpr_pkg::ProdW-1:0]  prod
);
  import tpr_pkg::*;

  logic [ProdW-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= ProdW'(a) * ProdW'(b);
  end

  assign prod = prod_r;
endmodule

### design/tach_pulse_rpm_filter.sv
// Channel   Dir  Payload
// in_ch     in   command (0 edge, 1 evaluate), time_us
// out_ch    out  filtered/raw rpm, presence, period, counters, min/max rpm
// cfg_ch    in   index (register 0..7), data; always ready
//
// An edge item is taken in idle and leaves no result.
// An evaluate item that divides runs from its accept through the bit-serial
// divider (rpm_numerator / period), then through steps on one shared,
// registered 24x16 multiplier for the spike, agreement and EMA math. With no
// signal or no period it skips the divider. No new item is taken until the
// block is back in idle.
// Synchronous active-low reset sets config to defaults and state to zero.
// The result sits in an output register; the block waits only if it is
// still untaken when the next result is ready.
module tach_pulse_rpm_filter (
  input logic clk,
  input logic rst_n,
  tpr_in_if.sink    in_ch,
  tpr_out_if.source out_ch,
  tpr_cfg_if.sink   cfg_ch
);
  import tpr_pkg::*;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DIV       = 4'd1;
  localparam logic [3:0] S_POST      = 4'd2;
  localparam logic [3:0] S_MUL_LOW   = 4'd3;
  localparam logic [3:0] S_MUL_HIGH  = 4'd4;
  localparam logic [3:0] S_AGREE     = 4'd5;
  localparam logic [3:0] S_ACC       = 4'd6;
  localparam logic [3:0] S_MED       = 4'd7;
  localparam logic [3:0] S_EMA_ISSUE = 4'd8;
  localparam logic [3:0] S_EMA       = 4'd9;
  localparam logic [3:0] S_MINMAX    = 4'd10;
  localparam logic [3:0] S_OUT       = 4'd11;

  localparam logic [RpmW-1:0] RpmMax = '1;
  localparam logic [CntW-1:0] CntMax = '1;

  function automatic logic [RpmW-1:0] median3(input logic [RpmW-1:0] a0,
                                              input logic [RpmW-1:0] b0,
                                              input logic [RpmW-1:0] c0);
    logic [RpmW-1:0] a, b, c, t;
    a = a0; b = b0; c = c0;
    if (a > b) begin t = a; a = b; b = t; end
    if (b > c) begin t = b; b = c; c = t; end
    if (a > b) begin t = a; a = b; b = t; end
    return b;
  endfunction

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    return (v == CntMax) ? v : v + 1'b1;
  endfunction

  // configuration
  logic [19:0]       min_pulse_r;
  logic [TimeW-1:0]  timeout_r, numer_r;
  logic [RpmW-1:0]   max_rpm_r, min_engine_r;
  logic [RatioW-1:0] low_ratio_r, high_ratio_r, alpha_r;

  // state
  logic [3:0]        state_r, state_nxt;
  logic [TimeW-1:0]  last_edge_r, last_edge_nxt;
  logic              edge_seen_r, edge_seen_nxt;
  logic [TimeW-1:0]  period_r, period_nxt;
  logic [CntW-1:0]   edges_r, edges_nxt;
  logic [CntW-1:0]   chatter_r, chatter_nxt;
  logic [CntW-1:0]   edges_eval_r, edges_eval_nxt;
  logic [RpmW-1:0]   smooth_r, smooth_nxt;
  logic [RpmW-1:0]   win_r [3];
  logic [RpmW-1:0]   win_nxt [3];
  logic [1:0]        fill_r, fill_nxt;
  logic [1:0]        slot_r, slot_nxt;
  logic [RpmW-1:0]   guess_r, guess_nxt;
  logic [7:0]        agree_cnt_r, agree_cnt_nxt;
  logic [CntW-1:0]   bad_r, bad_nxt;
  logic [CntW-1:0]   low_steps_r, low_steps_nxt;
  logic [CntW-1:0]   high_steps_r, high_steps_nxt;
  logic [CntW-1:0]   zero_drops_r, zero_drops_nxt;
  logic [RpmW-1:0]   lowest_r, lowest_nxt;
  logic [RpmW-1:0]   highest_r, highest_nxt;

  // per-evaluate working registers
  logic              present_r, present_nxt;
  logic [TimeW-1:0]  q_r, q_nxt;
  logic [RpmW-1:0]   prev_r, prev_nxt;
  logic              low_r, low_nxt;
  logic              reseed_r, reseed_nxt;
  logic [RpmW-1:0]   fin_r, fin_nxt;
  logic              out_valid_r, out_valid_nxt;

  // output payload
  logic [RpmW-1:0]   o_filt_r, o_raw_r, o_min_r, o_max_r;
  logic              o_present_r;
  logic [TimeW-1:0]  o_period_r;
  logic [CntW-1:0]   o_edges_r, o_chatter_r, o_bad_r, o_low_r, o_high_r, o_zero_r;
  logic              load_out;

  // shared units
  div_ctl_t          div_ctl;
  logic              div_done;
  logic [TimeW-1:0]  div_quo;
  logic [RpmW-1:0]   mul_a;
  logic [RatioW-1:0] mul_b;
  logic [ProdW-1:0]  prod;

  logic              in_acc;
  logic [TimeW-1:0]  gap;
  logic [TimeW-1:0]  age;
  logic [RpmW-1:0]   m24;
  logic [ProdW-1:0]  scaled;
  logic [RpmW-1:0]   step_diff;
  logic              agree;
  logic [7:0]        cnt_new;
  logic [1:0]        idx;
  logic [RpmW-1:0]   fin_c;
  logic [RpmW-1:0]   ema_d;
  logic [ProdW-1:0]  ema_sum;
  logic [RpmW-1:0]   ema_step;

  tpr_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_in (div_ctl),
    .num    (numer_r),
    .den    (period_r),
    .done   (div_done),
    .quo    (div_quo)
  );

  tpr_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign gap          = in_ch.time_us - last_edge_r;
  assign age          = in_ch.time_us - last_edge_r;
  assign m24          = q_r[RpmW-1:0];
  assign scaled       = ProdW'({m24, 8'd0});
  assign step_diff    = (m24 > guess_r) ? m24 - guess_r : guess_r - m24;
  assign idx          = (slot_r > 2'd2) ? 2'd0 : slot_r;
  assign fin_c        = (fill_r == 2'd3) ? median3(win_r[0], win_r[1], win_r[2]) : m24;
  assign ema_d        = (fin_r >= smooth_r) ? fin_r - smooth_r : smooth_r - fin_r;
  assign ema_sum      = prod + ProdW'(32768);
  assign ema_step     = ema_sum[RatioW +: RpmW];

  always_comb begin
    state_nxt      = state_r;
    last_edge_nxt  = last_edge_r;
    edge_seen_nxt  = edge_seen_r;
    period_nxt     = period_r;
    edges_nxt      = edges_r;
    chatter_nxt    = chatter_r;
    edges_eval_nxt = edges_eval_r;
    smooth_nxt     = smooth_r;
    win_nxt        = win_r;
    fill_nxt       = fill_r;
    slot_nxt       = slot_r;
    guess_nxt      = guess_r;
    agree_cnt_nxt  = agree_cnt_r;
    bad_nxt        = bad_r;
    low_steps_nxt  = low_steps_r;
    high_steps_nxt = high_steps_r;
    zero_drops_nxt = zero_drops_r;
    lowest_nxt     = lowest_r;
    highest_nxt    = highest_r;
    present_nxt    = present_r;
    q_nxt          = q_r;
    prev_nxt       = prev_r;
    low_nxt        = low_r;
    reseed_nxt     = reseed_r;
    fin_nxt        = fin_r;
    out_valid_nxt  = out_valid_r;
    load_out       = 1'b0;
    div_ctl        = '0;
    div_ctl.done   = div_done;
    mul_a          = smooth_r;
    mul_b          = low_ratio_r;
    agree          = 1'b0;
    cnt_new        = agree_cnt_r;

    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_ch.command == CMD_EDGE) begin
            if (!edge_seen_r || gap >= TimeW'(min_pulse_r)) begin
              if (edge_seen_r) period_nxt = gap;
              last_edge_nxt = in_ch.time_us;
              edge_seen_nxt = 1'b1;
              edges_nxt     = edges_r + 1'b1;
            end else begin
              chatter_nxt = sat_inc(chatter_r);
            end
          end else begin
            present_nxt = edge_seen_r && (age <= timeout_r);
            prev_nxt    = smooth_r;
            reseed_nxt  = 1'b0;
            q_nxt       = '0;
            if (edge_seen_r && (age <= timeout_r) && period_r != '0) begin
              div_ctl.start = 1'b1;
              state_nxt     = S_DIV;
            end else begin
              state_nxt = S_POST;
            end
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          q_nxt     = div_quo;
          state_nxt = S_POST;
        end
      end
      S_POST: begin
        state_nxt = S_OUT;
        if (!present_r) begin
          smooth_nxt    = '0;
          fill_nxt      = '0;
          slot_nxt      = '0;
          guess_nxt     = '0;
          agree_cnt_nxt = '0;
        end else if (edges_r != edges_eval_r && q_r != '0) begin
          if (q_r > TimeW'(max_rpm_r)) begin
            guess_nxt     = '0;
            agree_cnt_nxt = '0;
            bad_nxt       = sat_inc(bad_r);
          end else if (smooth_r > min_engine_r) begin
            mul_a     = smooth_r;
            mul_b     = low_ratio_r;
            state_nxt = S_MUL_LOW;
          end else begin
            guess_nxt     = '0;
            agree_cnt_nxt = '0;
            state_nxt     = S_ACC;
          end
        end
      end
      S_MUL_LOW: begin
        low_nxt   = scaled < prod;
        mul_a     = smooth_r;
        mul_b     = high_ratio_r;
        state_nxt = S_MUL_HIGH;
      end
      S_MUL_HIGH: begin
        if (low_r || scaled > prod) begin
          if (low_r) low_steps_nxt = sat_inc(low_steps_r);
          else high_steps_nxt = sat_inc(high_steps_r);
          mul_a     = guess_r;
          mul_b     = CONFIRM_TOLERANCE_Q16;
          state_nxt = S_AGREE;
        end else begin
          guess_nxt     = '0;
          agree_cnt_nxt = '0;
          state_nxt     = S_ACC;
        end
      end
      S_AGREE: begin
        agree = (agree_cnt_r != '0) && (guess_r != '0) &&
                ({step_diff, 16'd0} <= prod);
        if (agree) begin
          cnt_new = (agree_cnt_r == 8'hFF) ? agree_cnt_r : agree_cnt_r + 1'b1;
          guess_nxt = guess_r;
        end else begin
          cnt_new   = 8'd1;
          guess_nxt = m24;
        end
        agree_cnt_nxt = cnt_new;
        if (cnt_new >= CONFIRM_PULSES) begin
          reseed_nxt    = 1'b1;
          guess_nxt     = '0;
          agree_cnt_nxt = '0;
          state_nxt     = S_ACC;
        end else begin
          bad_nxt   = sat_inc(bad_r);
          state_nxt = S_OUT;
        end
      end
      S_ACC: begin
        if (reseed_r) begin
          win_nxt[0] = m24;
          win_nxt[1] = m24;
          win_nxt[2] = m24;
          fill_nxt   = 2'd1;
          slot_nxt   = 2'd1;
          smooth_nxt = m24;
          fin_nxt    = m24;
          state_nxt  = S_MINMAX;
        end else begin
          win_nxt[idx] = m24;
          slot_nxt     = (idx == 2'd2) ? 2'd0 : idx + 2'd1;
          if (fill_r < 2'd3) fill_nxt = fill_r + 2'd1;
          state_nxt = S_MED;
        end
      end
      S_MED: begin
        fin_nxt = fin_c;
        if (smooth_r == '0) begin
          smooth_nxt = fin_c;
          state_nxt  = S_MINMAX;
        end else begin
          state_nxt = S_EMA_ISSUE;
        end
      end
      S_EMA_ISSUE: begin
        mul_a     = ema_d;
        mul_b     = alpha_r;
        state_nxt = S_EMA;
      end
      S_EMA: begin
        if (fin_r >= smooth_r) smooth_nxt = smooth_r + ema_step;
        else smooth_nxt = smooth_r - ema_step;
        state_nxt = S_MINMAX;
      end
      S_MINMAX: begin
        if (lowest_r == '0 || fin_r < lowest_r) lowest_nxt = fin_r;
        if (fin_r > highest_r) highest_nxt = fin_r;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          load_out       = 1'b1;
          out_valid_nxt  = 1'b1;
          edges_eval_nxt = edges_r;
          if (prev_r > min_engine_r && smooth_r == '0)
            zero_drops_nxt = sat_inc(zero_drops_r);
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_pulse_r  <= 20'd1000;
      timeout_r    <= 32'd500000;
      numer_r      <= 32'd3932160000;
      max_rpm_r    <= 24'd2560000;
      min_engine_r <= 24'd76800;
      low_ratio_r  <= 16'd128;
      high_ratio_r <= 16'd512;
      alpha_r      <= 16'd19661;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        CFG_MIN_PULSE:  min_pulse_r  <= cfg_ch.data[19:0];
        CFG_TIMEOUT:    timeout_r    <= cfg_ch.data;
        CFG_NUMERATOR:  numer_r      <= cfg_ch.data;
        CFG_MAX_RPM:    max_rpm_r    <= cfg_ch.data[RpmW-1:0];
        CFG_MIN_ENGINE: min_engine_r <= cfg_ch.data[RpmW-1:0];
        CFG_LOW_RATIO:  low_ratio_r  <= cfg_ch.data[RatioW-1:0];
        CFG_HIGH_RATIO: high_ratio_r <= cfg_ch.data[RatioW-1:0];
        CFG_ALPHA:      alpha_r      <= cfg_ch.data[RatioW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      last_edge_r  <= '0;
      edge_seen_r  <= 1'b0;
      period_r     <= '0;
      edges_r      <= '0;
      chatter_r    <= '0;
      edges_eval_r <= '0;
      smooth_r     <= '0;
      win_r[0]     <= '0;
      win_r[1]     <= '0;
      win_r[2]     <= '0;
      fill_r       <= '0;
      slot_r       <= '0;
      guess_r      <= '0;
      agree_cnt_r  <= '0;
      bad_r        <= '0;
      low_steps_r  <= '0;
      high_steps_r <= '0;
      zero_drops_r <= '0;
      lowest_r     <= '0;
      highest_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      last_edge_r  <= last_edge_nxt;
      edge_seen_r  <= edge_seen_nxt;
      period_r     <= period_nxt;
      edges_r      <= edges_nxt;
      chatter_r    <= chatter_nxt;
      edges_eval_r <= edges_eval_nxt;
      smooth_r     <= smooth_nxt;
      win_r        <= win_nxt;
      fill_r       <= fill_nxt;
      slot_r       <= slot_nxt;
      guess_r      <= guess_nxt;
      agree_cnt_r  <= agree_cnt_nxt;
      bad_r        <= bad_nxt;
      low_steps_r  <= low_steps_nxt;
      high_steps_r <= high_steps_nxt;
      zero_drops_r <= zero_drops_nxt;
      lowest_r     <= lowest_nxt;
      highest_r    <= highest_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    present_r <= present_nxt;
    q_r       <= q_nxt;
    prev_r    <= prev_nxt;
    low_r     <= low_nxt;
    reseed_r  <= reseed_nxt;
    fin_r     <= fin_nxt;
  end

  // result register; zero-drop and the raw clamp are folded in at load
  always_ff @(posedge clk) begin
    if (load_out) begin
      o_filt_r    <= smooth_r;
      o_raw_r     <= (q_r > TimeW'(RpmMax)) ? RpmMax : q_r[RpmW-1:0];
      o_present_r <= present_r;
      o_period_r  <= period_r;
      o_edges_r   <= edges_r;
      o_chatter_r <= chatter_r;
      o_bad_r     <= bad_r;
      o_low_r     <= low_steps_r;
      o_high_r    <= high_steps_r;
      o_zero_r    <= zero_drops_nxt;
      o_min_r     <= lowest_r;
      o_max_r     <= highest_r;
    end
  end

  assign out_ch.valid                  = out_valid_r;
  assign out_ch.filtered_rpm           = o_filt_r;
  assign out_ch.raw_rpm                = o_raw_r;
  assign out_ch.signal_present         = o_present_r;
  assign out_ch.period_us              = o_period_r;
  assign out_ch.pulse_count            = o_edges_r;
  assign out_ch.rejected_pulse_count   = o_chatter_r;
  assign out_ch.rejected_reading_count = o_bad_r;
  assign out_ch.low_spike_count        = o_low_r;
  assign out_ch.high_spike_count       = o_high_r;
  assign out_ch.zero_drop_count        = o_zero_r;
  assign out_ch.min_accepted_rpm       = o_min_r;
  assign out_ch.max_accepted_rpm       = o_max_r;

  // the divider is only kicked from idle
  a_div_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_ctl.start |-> state_r == S_IDLE)
    else $error("divider started outside idle");

  // a confirmed step always reseeds and clears the guess and the agree count
  a_agree_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> agree_cnt_r < CONFIRM_PULSES)
    else $error("agree count left at confirm level");

  // a result loads only from the final step
  a_load_state: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_ch.valid && state_r == S_IDLE)
    else $error("result load out of sequence");
endmodule

### tb/tach_pulse_rpm_filter_tb.sv
module tach_pulse_rpm_filter_tb;
  import tpr_pkg::*;

  typedef struct packed {
    logic [RpmW-1:0]  filtered_rpm;
    logic [RpmW-1:0]  raw_rpm;
    logic             signal_present;
    logic [TimeW-1:0] period_us;
    logic [CntW-1:0]  pulse_count;
    logic [CntW-1:0]  rejected_pulse_count;
    logic [CntW-1:0]  rejected_reading_count;
    logic [CntW-1:0]  low_spike_count;
    logic [CntW-1:0]  high_spike_count;
    logic [CntW-1:0]  zero_drop_count;
    logic [RpmW-1:0]  min_accepted_rpm;
    logic [RpmW-1:0]  max_accepted_rpm;
  } rpm_report_t;

  // Tach model: mirrors the filter state and queues the expected reports.
  class tach_scoreboard;
    bit [19:0] min_gap;
    bit [31:0] timeout, numer;
    bit [23:0] max_rpm, min_engine;
    bit [15:0] low_ratio, high_ratio, alpha;
    bit [31:0] last_t, period, edges, chatter, edges_seen_eval;
    bit        seen;
    bit [23:0] smooth, win[3], guess, lowest, highest;
    bit [1:0]  fill, slot;
    bit [7:0]  agree_cnt;
    bit [31:0] bad, lows, highs, drops;
    rpm_report_t pending_reports[$];
    int errors;
    int evals_checked;

    function void reset_all();
      min_gap = 1000; timeout = 500000; numer = 32'd3932160000;
      max_rpm = 2560000; min_engine = 76800;
      low_ratio = 128; high_ratio = 512; alpha = 19661;
      last_t = 0; period = 0; edges = 0; chatter = 0; edges_seen_eval = 0;
      seen = 0; smooth = 0; win[0] = 0; win[1] = 0; win[2] = 0;
      guess = 0; lowest = 0; highest = 0; fill = 0; slot = 0; agree_cnt = 0;
      bad = 0; lows = 0; highs = 0; drops = 0;
      pending_reports.delete();
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, bit [31:0] v);
      case (idx)
        CFG_MIN_PULSE:  min_gap = v[19:0];
        CFG_TIMEOUT:    timeout = v;
        CFG_NUMERATOR:  numer = v;
        CFG_MAX_RPM:    max_rpm = v[23:0];
        CFG_MIN_ENGINE: min_engine = v[23:0];
        CFG_LOW_RATIO:  low_ratio = v[15:0];
        CFG_HIGH_RATIO: high_ratio = v[15:0];
        CFG_ALPHA:      alpha = v[15:0];
        default: ;
      endcase
    endfunction

    function bit [31:0] bump(bit [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 1;
    endfunction

    function bit [23:0] mid3(bit [23:0] a, bit [23:0] b, bit [23:0] c);
      bit [23:0] t;
      if (a > b) begin t = a; a = b; b = t; end
      if (b > c) begin t = b; b = c; c = t; end
      if (a > b) begin t = a; a = b; b = t; end
      return b;
    endfunction

    function void filter_reading(bit [31:0] m);
      bit ok, reseed, lo, hi, agree;
      bit [63:0] sc, d;
      bit [23:0] fin, m24;
      ok = 1; reseed = 0;
      m24 = m[23:0];
      if (m > max_rpm) begin
        ok = 0; guess = 0; agree_cnt = 0; bad = bump(bad);
      end else if (smooth > min_engine) begin
        sc = 64'(m) << 8;
        lo = sc < 64'(smooth) * low_ratio;
        hi = sc > 64'(smooth) * high_ratio;
        if (lo || hi) begin
          agree = 0;
          if (lo) lows = bump(lows);
          else highs = bump(highs);
          if (agree_cnt > 0 && guess > 0) begin
            d = (m > guess) ? 64'(m - guess) : 64'(guess - m);
            agree = (d << 16) <= 64'(guess) * CONFIRM_TOLERANCE_Q16;
          end
          if (agree) begin
            if (agree_cnt < 255) agree_cnt++;
          end else begin
            guess = m24; agree_cnt = 1;
          end
          if (agree_cnt >= CONFIRM_PULSES) begin
            reseed = 1; guess = 0; agree_cnt = 0;
          end else begin
            ok = 0; bad = bump(bad);
          end
        end else begin
          guess = 0; agree_cnt = 0;
        end
      end else begin
        guess = 0; agree_cnt = 0;
      end
      if (!ok) return;
      fin = m24;
      if (reseed) begin
        win[0] = m24; win[1] = m24; win[2] = m24;
        fill = 1; slot = 1; smooth = m24;
      end else begin
        if (slot > 2) slot = 0;
        win[slot] = m24;
        slot = (slot == 2) ? 0 : slot + 1;
        if (fill < 3) fill++;
        if (fill == 3) fin = mid3(win[0], win[1], win[2]);
        if (smooth == 0) smooth = fin;
        else if (fin >= smooth) begin
          d = 64'(fin - smooth);
          smooth = smooth + 24'((d * alpha + 32768) >> 16);
        end else begin
          d = 64'(smooth - fin);
          smooth = smooth - 24'((d * alpha + 32768) >> 16);
        end
      end
      if (lowest == 0 || fin < lowest) lowest = fin;
      if (fin > highest) highest = fin;
    endfunction

    // Notes an accepted input item; evaluates queue one expected report.
    function void note_input(logic cmd, bit [31:0] now);
      bit present;
      bit [31:0] q, gap, prev;
      rpm_report_t r;
      if (cmd == CMD_EDGE) begin
        gap = now - last_t;
        if (!seen || gap >= min_gap) begin
          if (seen) period = gap;
          last_t = now; seen = 1; edges++;
        end else chatter = bump(chatter);
        return;
      end
      present = seen && (now - last_t) <= timeout;
      prev = smooth;
      q = (present && period > 0) ? numer / period : 0;
      if (!present) begin
        smooth = 0; fill = 0; slot = 0; guess = 0; agree_cnt = 0;
      end else if (edges != edges_seen_eval && q > 0) filter_reading(q);
      if (prev > min_engine && smooth == 0) drops = bump(drops);
      edges_seen_eval = edges;
      r.filtered_rpm = smooth;
      r.raw_rpm = (q > 32'hFF_FFFF) ? 24'hFF_FFFF : q[23:0];
      r.signal_present = present;
      r.period_us = period;
      r.pulse_count = edges;
      r.rejected_pulse_count = chatter;
      r.rejected_reading_count = bad;
      r.low_spike_count = lows;
      r.high_spike_count = highs;
      r.zero_drop_count = drops;
      r.min_accepted_rpm = lowest;
      r.max_accepted_rpm = highest;
      pending_reports.push_back(r);
    endfunction

    function void check_report(rpm_report_t a);
      rpm_report_t e;
      if (pending_reports.size() == 0) begin
        $error("report with none expected");
        errors++;
        return;
      end
      e = pending_reports.pop_front();
      evals_checked++;
      if (a.filtered_rpm !== e.filtered_rpm) begin
        $error("filtered_rpm exp %0d got %0d", e.filtered_rpm, a.filtered_rpm); errors++;
      end
      if (a.raw_rpm !== e.raw_rpm) begin
        $error("raw_rpm exp %0d got %0d", e.raw_rpm, a.raw_rpm); errors++;
      end
      if (a.signal_present !== e.signal_present) begin
        $error("signal_present exp %0d got %0d", e.signal_present, a.signal_present);
        errors++;
      end
      if (a.period_us !== e.period_us) begin
        $error("period_us exp %0d got %0d", e.period_us, a.period_us); errors++;
      end
      if (a.pulse_count !== e.pulse_count) begin
        $error("pulse_count exp %0d got %0d", e.pulse_count, a.pulse_count); errors++;
      end
      if (a.rejected_pulse_count !== e.rejected_pulse_count) begin
        $error("rejected_pulse_count exp %0d got %0d", e.rejected_pulse_count,
               a.rejected_pulse_count); errors++;
      end
      if (a.rejected_reading_count !== e.rejected_reading_count) begin
        $error("rejected_reading_count exp %0d got %0d", e.rejected_reading_count,
               a.rejected_reading_count); errors++;
      end
      if (a.low_spike_count !== e.low_spike_count) begin
        $error("low_spike_count exp %0d got %0d", e.low_spike_count,
               a.low_spike_count); errors++;
      end
      if (a.high_spike_count !== e.high_spike_count) begin
        $error("high_spike_count exp %0d got %0d", e.high_spike_count,
               a.high_spike_count); errors++;
      end
      if (a.zero_drop_count !== e.zero_drop_count) begin
        $error("zero_drop_count exp %0d got %0d", e.zero_drop_count,
               a.zero_drop_count); errors++;
      end
      if (a.min_accepted_rpm !== e.min_accepted_rpm) begin
        $error("min_accepted_rpm exp %0d got %0d", e.min_accepted_rpm,
               a.min_accepted_rpm); errors++;
      end
      if (a.max_accepted_rpm !== e.max_accepted_rpm) begin
        $error("max_accepted_rpm exp %0d got %0d", e.max_accepted_rpm,
               a.max_accepted_rpm); errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  tpr_in_if  in_ch();
  tpr_out_if out_ch();
  tpr_cfg_if cfg_ch();

  tach_pulse_rpm_filter uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  tach_scoreboard tach_sb;
  bit [31:0] tach_now;        // running timestamp for generated edges
  bit        sink_free_run;   // no stalls at the output
  bit        sink_hold_req;   // long output hold-off requested
  int        items_sent;
  int        evals_sent;

  initial begin
    forever #5 clk = ~clk;
  end

  // Safety net: far above the slowest legal run of ~2k items.
  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.command = CMD_EDGE;
    in_ch.time_us = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_MIN_PULSE;
    cfg_ch.data = '0;
  end

  // Output side: random stall bursts, one long hold-off on request.
  initial begin
    int n;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (sink_hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(negedge clk);
        sink_hold_req = 1'b0;
        out_ch.ready <= 1'b1;
      end else if (!sink_free_run && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 9);
        out_ch.ready <= 1'b0;
        repeat (n) @(negedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Checks every accepted report against the model.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      rpm_report_t a;
      a.filtered_rpm = out_ch.filtered_rpm;
      a.raw_rpm = out_ch.raw_rpm;
      a.signal_present = out_ch.signal_present;
      a.period_us = out_ch.period_us;
      a.pulse_count = out_ch.pulse_count;
      a.rejected_pulse_count = out_ch.rejected_pulse_count;
      a.rejected_reading_count = out_ch.rejected_reading_count;
      a.low_spike_count = out_ch.low_spike_count;
      a.high_spike_count = out_ch.high_spike_count;
      a.zero_drop_count = out_ch.zero_drop_count;
      a.min_accepted_rpm = out_ch.min_accepted_rpm;
      a.max_accepted_rpm = out_ch.max_accepted_rpm;
      tach_sb.check_report(a);
    end
  end

  // Offers one item and waits for its acceptance; the model is updated at the
  // accepting edge. With gaps set, random gap bursts may come before the item.
  task automatic send_item(logic cmd, bit [31:0] t, bit gaps);
    if (gaps && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.time_us <= t;
    do @(posedge clk); while (!in_ch.ready);
    tach_sb.note_input(cmd, t);
    items_sent++;
    if (cmd == CMD_EVAL) evals_sent++;
    @(negedge clk);
  endtask

  task automatic idle_input();
    in_ch.valid <= 1'b0;
  endtask

  // Waits until every expected report has arrived, plus the evaluate latency.
  task automatic drain_reports();
    idle_input();
    while (tach_sb.pending_reports.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_cfg(logic [CfgIdxW-1:0] idx, bit [31:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    tach_sb.write_reg(idx, v);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Edge spaced by dt from the running timestamp.
  task automatic edge_after(bit [31:0] dt, bit gaps);
    tach_now = tach_now + dt;
    send_item(CMD_EDGE, tach_now, gaps);
  endtask

  task automatic eval_after(bit [31:0] dt, bit gaps);
    send_item(CMD_EVAL, tach_now + dt, gaps);
  endtask

  // Mostly steady tach trains with occasional chatter, steps, dropouts and
  // raw random items.
  task automatic random_phase(int count, bit gaps, bit [31:0] base_period);
    bit [31:0] per;
    int k;
    per = base_period;
    k = 0;
    while (k < count) begin
      case ($urandom_range(0, 19))
        0: begin
          send_item(logic'($urandom_range(0, 1)), $urandom, gaps); k++;
        end
        1: begin
          edge_after($urandom_range(0, 900), gaps); k++;  // chatter
        end
        2: per = $urandom_range(50, 400000);              // large step
        3: begin
          eval_after(32'd600000 + $urandom_range(0, 100000), gaps); k++; // lost
        end
        default: begin
          per = per + $urandom_range(0, 200) - 100;
          if (per < 20) per = 20;
          edge_after(per, gaps); k++;
          if ($urandom_range(0, 2) == 0) begin
            eval_after($urandom_range(0, 50), gaps); k++;
          end
        end
      endcase
    end
    idle_input();
  endtask

  initial begin
    tach_sb = new();
    tach_sb.reset_all();
    tach_now = 32'd100;
    sink_free_run = 1'b0;
    sink_hold_req = 1'b0;
    items_sent = 0;
    evals_sent = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: defaults, eval before any edge, first edge, zero-stamp edge.
    eval_after(0, 0);
    send_item(CMD_EDGE, 32'd0, 0);
    tach_now = 0;
    eval_after(5, 0);                 // first edge only, no period
    edge_after(999, 0);               // chatter, just under minimum
    edge_after(1, 0);                 // exactly at minimum
    eval_after(0, 0);
    eval_after(10, 0);                // no new edge since last evaluate
    edge_after(20000, 0);
    eval_after(0, 0);
    edge_after(20000, 0);
    eval_after(0, 0);
    edge_after(20000, 0);
    eval_after(0, 0);
    edge_after(5000, 0);              // high step, needs confirmation
    eval_after(0, 0);
    edge_after(5000, 0);              // confirmed, reseed
    eval_after(0, 0);
    edge_after(1000, 0);              // over range
    eval_after(0, 0);
    eval_after(32'd500000, 0);        // timeout edge, still present
    eval_after(32'd500001, 0);        // lost
    tach_now = 32'hFFFF_FF00;
    send_item(CMD_EDGE, tach_now, 0);
    edge_after(32'h0000_2000, 0);     // timestamp wrap
    eval_after(0, 0);
    drain_reports();

    // Extremes: huge and tiny numerator, saturating quotient, zero high ratio.
    write_cfg(CFG_MIN_PULSE, 32'h000F_FFFF);
    write_cfg(CFG_TIMEOUT, 32'hFFFF_FFFF);
    write_cfg(CFG_NUMERATOR, 32'hFFFF_FFFF);
    write_cfg(CFG_MAX_RPM, 32'h00FF_FFFF);
    write_cfg(CFG_MIN_ENGINE, 32'd0);
    write_cfg(CFG_LOW_RATIO, 32'hFFFF);
    write_cfg(CFG_HIGH_RATIO, 32'd0);
    write_cfg(CFG_ALPHA, 32'hFFFF);
    write_cfg(CFG_MIN_PULSE, 32'd0);
    random_phase(300, 1, 32'd40);
    drain_reports();

    write_cfg(CFG_NUMERATOR, 32'd1);
    write_cfg(CFG_MAX_RPM, 32'd0);
    write_cfg(CFG_ALPHA, 32'd0);
    write_cfg(CFG_TIMEOUT, 32'd0);
    random_phase(150, 1, 32'd1);
    drain_reports();

    // Back to defaults, plus the long output hold-off with input pressure.
    tach_sb.write_reg(CFG_MIN_PULSE, 0);
    write_cfg(CFG_MIN_PULSE, 32'd1000);
    write_cfg(CFG_TIMEOUT, 32'd500000);
    write_cfg(CFG_NUMERATOR, 32'd3932160000);
    write_cfg(CFG_MAX_RPM, 32'd2560000);
    write_cfg(CFG_MIN_ENGINE, 32'd76800);
    write_cfg(CFG_LOW_RATIO, 32'd128);
    write_cfg(CFG_HIGH_RATIO, 32'd512);
    write_cfg(CFG_ALPHA, 32'd19661);
    sink_hold_req = 1'b1;
    random_phase(700, 1, 32'd20000);
    drain_reports();               // sender paused until all reports came

    // Tighter spike thresholds, mid alpha, no idling at the end.
    write_cfg(CFG_LOW_RATIO, 32'd230);
    write_cfg(CFG_HIGH_RATIO, 32'd282);
    write_cfg(CFG_ALPHA, 32'd32768);
    write_cfg(CFG_MIN_ENGINE, 32'd1000);
    random_phase(400, 1, 32'd8000);
    sink_free_run = 1'b1;
    random_phase(200, 0, 32'd3000);
    drain_reports();

    $display("Run covered %0d items, %0d evaluate reports checked, over 5 settings.",
             items_sent, tach_sb.evals_checked);
    if (tach_sb.errors == 0 && tach_sb.pending_reports.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

### sim.f
design/tpr_pkg.sv
design/tpr_if.sv
design/tpr_div.sv
design/tpr_mul.sv
design/tach_pulse_rpm_filter.sv
tb/tach_pulse_rpm_filter_tb.sv
